[rtl/gcb_pkg.sv]
// shared types and constants for the growable character buffer
`timescale 1ns / 1ps

package gcb_pkg;

   localparam int STORE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CHAR_W      = 8;
   localparam int FACTOR_W    = 8;
   localparam int MODE_W      = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 12;
   localparam int STATUS_W    = 3;
   localparam int OP_W        = 4;

   localparam logic [ADDR_W-1:0]   MAX_CAP       = ADDR_W'(STORE_DEPTH - 1);
   localparam logic [FACTOR_W-1:0] PERCENT_FULL  = FACTOR_W'(100);
   localparam logic [ADDR_W-1:0]   START_CAP_RST = ADDR_W'(200);

   typedef enum logic [OP_W-1:0] {
      OP_INIT          = 4'd0,
      OP_APPEND        = 4'd1,
      OP_GET           = 4'd2,
      OP_MARK          = 4'd3,
      OP_RETRACT       = 4'd4,
      OP_RESET_TO_MARK = 4'd5,
      OP_REWIND        = 4'd6,
      OP_CLEAR         = 4'd7,
      OP_COMPACT       = 4'd8,
      OP_READ_AT       = 4'd9
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_REFUSED = 3'd1,
      ST_END     = 3'd2,
      ST_BADPOS  = 3'd3,
      ST_BADCFG  = 3'd4,
      ST_UNDER   = 3'd5
   } status_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_FIXED = 2'd0,
      MODE_ADD   = 2'd1,
      MODE_MUL   = 2'd2,
      MODE_BAD   = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GROW_MODE   = 2'd0,
      CSR_GROW_FACTOR = 2'd1,
      CSR_START_CAP   = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [CHAR_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } ram_rd_type;

   typedef struct packed {
      logic                start;
      logic [ADDR_W-1:0]   room;
      logic [FACTOR_W-1:0] factor;
   } grow_req_type;

   typedef struct packed {
      logic              done;
      logic [ADDR_W-1:0] step;
   } grow_rsp_type;

   typedef struct packed {
      status_type        status;
      logic [CHAR_W-1:0] data_char;
      logic [ADDR_W-1:0] cur_capacity;
      logic [ADDR_W-1:0] fill_count;
      logic [ADDR_W-1:0] read_offset;
      logic [ADDR_W-1:0] mark_offset;
      logic              end_reached;
      logic              grew_flag;
      logic              full_flag;
      logic              empty_flag;
   } rsp_type;

endpackage

[rtl/gcb_char_ram.sv]
// character store: one write port, one registered read port
`timescale 1ns / 1ps

module gcb_char_ram (
   input  logic                        clock,
   input  gcb_pkg::ram_wr_type         wr,
   input  gcb_pkg::ram_rd_type         rd,
   output logic [gcb_pkg::CHAR_W-1:0]  rd_data
);
   import gcb_pkg::*;

   logic [CHAR_W-1:0] mem [STORE_DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/gcb_grow_unit.sv]
// two-stage step calculation: room * percent / 100
`timescale 1ns / 1ps

module gcb_grow_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  gcb_pkg::grow_req_type req,
   output gcb_pkg::grow_rsp_type rsp
);
   import gcb_pkg::*;

   localparam int PROD_W      = ADDR_W + FACTOR_W;
   localparam int RECIP_SHIFT = 26;
   localparam int RECIP_W     = 20;
   // ceil(2^26 / 100), exact floor quotient for products below 2^20
   localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'((64'd1 << RECIP_SHIFT) / 100 + 1);
   localparam int FULL_W      = PROD_W + RECIP_W;

   logic              v1_ff, v1_in;
   logic              v2_ff, v2_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [ADDR_W-1:0] step_ff, step_in;
   logic [FULL_W-1:0] scaled;

   always_comb begin
      prod_in = PROD_W'(req.room) * PROD_W'(req.factor);
      scaled  = FULL_W'(prod_ff) * FULL_W'(RECIP_100);
      step_in = scaled[RECIP_SHIFT +: ADDR_W];
      v1_in   = req.start;
      v2_in   = v1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      step_ff <= step_in;
   end

   assign rsp.done = v2_ff;
   assign rsp.step = step_ff;

endmodule

[rtl/growable_char_buffer.sv]
// growable character buffer: top level with control sequencer
`timescale 1ns / 1ps
//
// Character store with a logical capacity inside a 4096-entry memory.
// req_ channel: one operation (op, symbol, position) per request.
// rsp_ channel: exactly one result per request, in order, showing status,
// the returned character and the buffer view after the operation.
// csr_ channel: writes grow_mode (0), grow_factor (1), start_capacity (2);
// always ready, takes effect at the next init operation.
// Get and read_at pass through a read state for the registered memory read;
// an append that grows the capacity in multiplicative mode waits in a grow
// state for the two-stage multiply and reciprocal divide by 100.
// A single sequencer walks accept, execute, (wait) and result load, and
// takes no new request until the last one has been loaded as a result.
// The result sits in an output register; a new request is accepted while
// it waits. A stalled receiver holds the sequencer in its result state
// once the next result is ready.
// Reset clears pointers, capacity, flags and latched grow policy; the
// memory is not cleared and needs no clearing pass.
//

module growable_char_buffer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [gcb_pkg::OP_W-1:0]       req_op,
   input  logic [gcb_pkg::CHAR_W-1:0]     req_symbol,
   input  logic [gcb_pkg::ADDR_W-1:0]     req_position,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [gcb_pkg::STATUS_W-1:0]   rsp_status,
   output logic [gcb_pkg::CHAR_W-1:0]     rsp_data_char,
   output logic [gcb_pkg::ADDR_W-1:0]     rsp_cur_capacity,
   output logic [gcb_pkg::ADDR_W-1:0]     rsp_fill_count,
   output logic [gcb_pkg::ADDR_W-1:0]     rsp_read_offset,
   output logic [gcb_pkg::ADDR_W-1:0]     rsp_mark_offset,
   output logic                           rsp_end_reached,
   output logic                           rsp_grew_flag,
   output logic                           rsp_full_flag,
   output logic                           rsp_empty_flag,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gcb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gcb_pkg::CSR_DATA_W-1:0] csr_data
);
   import gcb_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_GROW = 5'b00100,
      S_READ = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [CHAR_W-1:0]   sym_ff, sym_in;
   logic [ADDR_W-1:0]   pos_ff, pos_in;
   logic [ADDR_W-1:0]   cap_ff, cap_in;
   logic [ADDR_W-1:0]   wp_ff, wp_in;
   logic [ADDR_W-1:0]   rp_ff, rp_in;
   logic [ADDR_W-1:0]   mark_ff, mark_in;
   logic                end_ff, end_in;
   logic                grew_ff, grew_in;
   mode_type            pol_mode_ff, pol_mode_in;
   logic [FACTOR_W-1:0] pol_factor_ff, pol_factor_in;
   mode_type            cfg_mode_ff, cfg_mode_in;
   logic [FACTOR_W-1:0] cfg_factor_ff, cfg_factor_in;
   logic [ADDR_W-1:0]   cfg_start_ff, cfg_start_in;
   status_type          status_ff, status_in;
   logic [CHAR_W-1:0]   data_ff, data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   ram_wr_type          ram_wr;
   ram_rd_type          ram_rd;
   logic [CHAR_W-1:0]   ram_rd_data;
   grow_req_type        grow_req;
   grow_rsp_type        grow_rsp;

   logic [ADDR_W:0]     add_sum;
   logic [ADDR_W:0]     mul_sum;
   logic                init_bad;

   gcb_char_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (ram_rd_data)
   );

   gcb_grow_unit u_grow (
      .clock (clock),
      .reset (reset),
      .req   (grow_req),
      .rsp   (grow_rsp)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      sym_in        = sym_ff;
      pos_in        = pos_ff;
      cap_in        = cap_ff;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      mark_in       = mark_ff;
      end_in        = end_ff;
      grew_in       = grew_ff;
      pol_mode_in   = pol_mode_ff;
      pol_factor_in = pol_factor_ff;
      cfg_mode_in   = cfg_mode_ff;
      cfg_factor_in = cfg_factor_ff;
      cfg_start_in  = cfg_start_ff;
      status_in     = status_ff;
      data_in       = data_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;

      ram_wr        = '0;
      ram_rd        = '0;
      grow_req      = '0;

      add_sum  = {1'b0, cap_ff} + {{(ADDR_W + 1 - FACTOR_W){1'b0}}, pol_factor_ff};
      mul_sum  = {1'b0, cap_ff} + {1'b0, grow_rsp.step};
      init_bad = ({1'b0, cfg_start_ff} > {1'b0, MAX_CAP})
               || (cfg_mode_ff == MODE_BAD)
               || (cfg_mode_ff == MODE_FIXED && cfg_start_ff == '0)
               || (cfg_mode_ff == MODE_MUL && cfg_factor_ff != '0
                   && cfg_factor_ff > PERCENT_FULL);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_GROW_MODE:   cfg_mode_in   = mode_type'(csr_data[MODE_W-1:0]);
            CSR_GROW_FACTOR: cfg_factor_in = csr_data[FACTOR_W-1:0];
            CSR_START_CAP:   cfg_start_in  = csr_data[ADDR_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = op_type'(req_op);
               sym_in   = req_symbol;
               pos_in   = req_position;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            status_in = ST_OK;
            data_in   = '0;
            state_in  = S_DONE;
            case (op_ff)
               OP_INIT: begin
                  if (init_bad) begin
                     status_in = ST_BADCFG;
                  end else begin
                     if (cfg_mode_ff == MODE_FIXED || cfg_factor_ff == '0) begin
                        pol_mode_in   = MODE_FIXED;
                        pol_factor_in = '0;
                     end else begin
                        pol_mode_in   = cfg_mode_ff;
                        pol_factor_in = cfg_factor_ff;
                     end
                     cap_in  = cfg_start_ff;
                     wp_in   = '0;
                     rp_in   = '0;
                     mark_in = '0;
                     end_in  = 1'b0;
                     grew_in = 1'b0;
                  end
               end
               OP_APPEND: begin
                  grew_in = 1'b0;
                  if (wp_ff < cap_ff) begin
                     ram_wr = '{en: 1'b1, addr: wp_ff, data: sym_ff};
                     wp_in  = wp_ff + 1'b1;
                  end else if (pol_mode_ff == MODE_FIXED || cap_ff >= MAX_CAP) begin
                     status_in = ST_REFUSED;
                  end else if (pol_mode_ff == MODE_ADD) begin
                     cap_in  = (add_sum > {1'b0, MAX_CAP}) ? MAX_CAP : add_sum[ADDR_W-1:0];
                     grew_in = 1'b1;
                     ram_wr  = '{en: 1'b1, addr: wp_ff, data: sym_ff};
                     wp_in   = wp_ff + 1'b1;
                  end else begin
                     // multiplicative: wait for the step from the grow unit
                     grow_req = '{start: 1'b1, room: MAX_CAP - cap_ff,
                                  factor: pol_factor_ff};
                     state_in = S_GROW;
                  end
               end
               OP_GET: begin
                  if (rp_ff >= wp_ff) begin
                     end_in    = 1'b1;
                     status_in = ST_END;
                  end else begin
                     end_in   = 1'b0;
                     ram_rd   = '{en: 1'b1, addr: rp_ff};
                     rp_in    = rp_ff + 1'b1;
                     state_in = S_READ;
                  end
               end
               OP_MARK: begin
                  if (pos_ff > wp_ff) begin
                     status_in = ST_BADPOS;
                  end else begin
                     mark_in = pos_ff;
                  end
               end
               OP_RETRACT: begin
                  if (rp_ff == '0) begin
                     status_in = ST_UNDER;
                  end else begin
                     rp_in = rp_ff - 1'b1;
                  end
               end
               OP_RESET_TO_MARK: begin
                  rp_in = mark_ff;
               end
               OP_REWIND: begin
                  rp_in   = '0;
                  mark_in = '0;
               end
               OP_CLEAR: begin
                  wp_in   = '0;
                  rp_in   = '0;
                  mark_in = '0;
                  end_in  = 1'b0;
                  grew_in = 1'b0;
               end
               OP_COMPACT: begin
                  if (wp_ff >= MAX_CAP) begin
                     grew_in   = 1'b0;
                     status_in = ST_REFUSED;
                  end else begin
                     cap_in  = wp_ff + 1'b1;
                     grew_in = 1'b1;
                     ram_wr  = '{en: 1'b1, addr: wp_ff, data: sym_ff};
                     wp_in   = wp_ff + 1'b1;
                  end
               end
               OP_READ_AT: begin
                  if (pos_ff >= wp_ff) begin
                     status_in = ST_BADPOS;
                  end else begin
                     ram_rd   = '{en: 1'b1, addr: pos_ff};
                     state_in = S_READ;
                  end
               end
               default: ;
            endcase
         end

         S_GROW: begin
            if (grow_rsp.done) begin
               // zero step or overshoot jumps straight to the maximum
               if (grow_rsp.step == '0 || mul_sum >= {1'b0, MAX_CAP}) begin
                  cap_in = MAX_CAP;
               end else begin
                  cap_in = mul_sum[ADDR_W-1:0];
               end
               grew_in  = 1'b1;
               ram_wr   = '{en: 1'b1, addr: wp_ff, data: sym_ff};
               wp_in    = wp_ff + 1'b1;
               state_in = S_DONE;
            end
         end

         S_READ: begin
            data_in  = ram_rd_data;
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = status_ff;
               rsp_in.data_char    = data_ff;
               rsp_in.cur_capacity = cap_ff;
               rsp_in.fill_count   = wp_ff;
               rsp_in.read_offset  = rp_ff;
               rsp_in.mark_offset  = mark_ff;
               rsp_in.end_reached  = end_ff;
               rsp_in.grew_flag    = grew_ff;
               rsp_in.full_flag    = (wp_ff == cap_ff);
               rsp_in.empty_flag   = (wp_ff == '0);
               state_in            = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cap_ff        <= '0;
         wp_ff         <= '0;
         rp_ff         <= '0;
         mark_ff       <= '0;
         end_ff        <= 1'b0;
         grew_ff       <= 1'b0;
         pol_mode_ff   <= MODE_FIXED;
         pol_factor_ff <= '0;
         cfg_mode_ff   <= MODE_FIXED;
         cfg_factor_ff <= '0;
         cfg_start_ff  <= START_CAP_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cap_ff        <= cap_in;
         wp_ff         <= wp_in;
         rp_ff         <= rp_in;
         mark_ff       <= mark_in;
         end_ff        <= end_in;
         grew_ff       <= grew_in;
         pol_mode_ff   <= pol_mode_in;
         pol_factor_ff <= pol_factor_in;
         cfg_mode_ff   <= cfg_mode_in;
         cfg_factor_ff <= cfg_factor_in;
         cfg_start_ff  <= cfg_start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      sym_ff    <= sym_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      data_ff   <= data_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_data_char    = rsp_ff.data_char;
   assign rsp_cur_capacity = rsp_ff.cur_capacity;
   assign rsp_fill_count   = rsp_ff.fill_count;
   assign rsp_read_offset  = rsp_ff.read_offset;
   assign rsp_mark_offset  = rsp_ff.mark_offset;
   assign rsp_end_reached  = rsp_ff.end_reached;
   assign rsp_grew_flag    = rsp_ff.grew_flag;
   assign rsp_full_flag    = rsp_ff.full_flag;
   assign rsp_empty_flag   = rsp_ff.empty_flag;

   // fill count never passes the logical capacity
   assert property (@(posedge clock) disable iff (reset) wp_ff <= cap_ff)
      else $error("fill count above capacity");

   // read and mark positions stay inside the written data
   assert property (@(posedge clock) disable iff (reset)
      (rp_ff <= wp_ff) && (mark_ff <= wp_ff))
      else $error("read or mark offset beyond fill count");

   // the grow unit only answers while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      grow_rsp.done |-> (state_ff == S_GROW))
      else $error("grow step arrived outside the grow wait");

   // a finished request is loaded into the result register
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid_ff)
      else $error("result not presented after completion");

endmodule

[bench/growable_char_buffer_test.sv]
// self-checking testbench for the growable character buffer
`timescale 1ns / 1ps

module growable_char_buffer_test;
   import gcb_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int RANDOM_REQUESTS = 1900;
   localparam logic [OP_W-1:0] OP_SPARE_FIRST = 4'd10;
   localparam logic [OP_W-1:0] OP_SPARE_LAST = 4'd15;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [CHAR_W-1:0] symbol;
      logic [ADDR_W-1:0] position;
      bit                typed;
      status_type        want_status;
      logic [CHAR_W-1:0] want_char;
   } directed_step_type;

   typedef struct {
      mode_type            mode;
      logic [FACTOR_W-1:0] factor;
      logic [ADDR_W-1:0]   start;
   } policy_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [OP_W-1:0] req_op = '0;
   logic [CHAR_W-1:0] req_symbol = '0;
   logic [ADDR_W-1:0] req_position = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [CHAR_W-1:0] rsp_data_char;
   logic [ADDR_W-1:0] rsp_cur_capacity;
   logic [ADDR_W-1:0] rsp_fill_count;
   logic [ADDR_W-1:0] rsp_read_offset;
   logic [ADDR_W-1:0] rsp_mark_offset;
   logic rsp_end_reached;
   logic rsp_grew_flag;
   logic rsp_full_flag;
   logic rsp_empty_flag;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // register copies and the buffer view they produce
   mode_type cfg_mode = MODE_FIXED;
   logic [FACTOR_W-1:0] cfg_factor = '0;
   logic [ADDR_W-1:0] cfg_start = START_CAP_RST;
   mode_type latched_mode = MODE_FIXED;
   logic [FACTOR_W-1:0] latched_factor = '0;
   logic [ADDR_W-1:0] view_cap = '0;
   logic [ADDR_W-1:0] view_fill = '0;
   logic [ADDR_W-1:0] view_rd = '0;
   logic [ADDR_W-1:0] view_mark = '0;
   logic view_end = 1'b0;
   logic view_grew = 1'b0;
   logic [CHAR_W-1:0] char_copy [STORE_DEPTH];

   rsp_type pending_views [$];
   int requests_sent = 0;
   int views_checked = 0;
   int bad_views = 0;
   int phases_run = 0;
   int cycles = 0;
   int hold_left = 0;
   bit calm = 1'b0;

   directed_step_type directed_rows [26] = '{
      '{OP_APPEND,        8'hff, 12'd0,    1'b1, ST_REFUSED, 8'h00},
      '{OP_GET,           8'h00, 12'd0,    1'b1, ST_END,     8'h00},
      '{OP_RETRACT,       8'h00, 12'd0,    1'b1, ST_UNDER,   8'h00},
      '{OP_MARK,          8'h00, 12'd1,    1'b1, ST_BADPOS,  8'h00},
      '{OP_READ_AT,       8'h00, 12'd0,    1'b1, ST_BADPOS,  8'h00},
      '{OP_SPARE_LAST,    8'hff, 12'hfff,  1'b1, ST_OK,      8'h00},
      '{OP_INIT,          8'h00, 12'd0,    1'b1, ST_OK,      8'h00},
      '{OP_APPEND,        8'h00, 12'd0,    1'b1, ST_OK,      8'h00},
      '{OP_APPEND,        8'hff, 12'd0,    1'b1, ST_OK,      8'h00},
      '{OP_APPEND,        8'h5a, 12'd0,    1'b0, ST_OK,      8'h00},
      '{OP_READ_AT,       8'h00, 12'd0,    1'b1, ST_OK,      8'h00},
      '{OP_READ_AT,       8'h00, 12'd1,    1'b1, ST_OK,      8'hff},
      '{OP_READ_AT,       8'h00, 12'hfff,  1'b1, ST_BADPOS,  8'h00},
      '{OP_MARK,          8'h00, 12'hfff,  1'b1, ST_BADPOS,  8'h00},
      '{OP_MARK,          8'h00, 12'd2,    1'b0, ST_OK,      8'h00},
      '{OP_GET,           8'h00, 12'd0,    1'b1, ST_OK,      8'h00},
      '{OP_GET,           8'h00, 12'd0,    1'b1, ST_OK,      8'hff},
      '{OP_RESET_TO_MARK, 8'h00, 12'd0,    1'b0, ST_OK,      8'h00},
      '{OP_RETRACT,       8'h00, 12'd0,    1'b0, ST_OK,      8'h00},
      '{OP_GET,           8'h00, 12'd0,    1'b0, ST_OK,      8'h00},
      '{OP_GET,           8'h00, 12'd0,    1'b0, ST_OK,      8'h00},
      '{OP_GET,           8'h00, 12'd0,    1'b1, ST_END,     8'h00},
      '{OP_REWIND,        8'h00, 12'd0,    1'b0, ST_OK,      8'h00},
      '{OP_COMPACT,       8'h80, 12'd0,    1'b0, ST_OK,      8'h00},
      '{OP_CLEAR,         8'h00, 12'd0,    1'b0, ST_OK,      8'h00},
      '{OP_READ_AT,       8'h00, 12'd0,    1'b1, ST_BADPOS,  8'h00}
   };

   policy_type fixed_policies [13] = '{
      '{MODE_FIXED, 8'd0,   12'd1},
      '{MODE_ADD,   8'd1,   12'd5},
      '{MODE_ADD,   8'd255, 12'd10},
      '{MODE_MUL,   8'd100, 12'd1},
      '{MODE_MUL,   8'd1,   12'd4090},
      '{MODE_MUL,   8'd50,  12'd0},
      '{MODE_BAD,   8'd5,   12'd8},
      '{MODE_FIXED, 8'd7,   12'd0},
      '{MODE_MUL,   8'd101, 12'd6},
      '{MODE_MUL,   8'd255, 12'hfff},
      '{MODE_ADD,   8'd0,   12'd0},
      '{MODE_FIXED, 8'd255, 12'hfff},
      '{MODE_ADD,   8'd37,  12'd3}
   };

   growable_char_buffer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_symbol       (req_symbol),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_data_char    (rsp_data_char),
      .rsp_cur_capacity (rsp_cur_capacity),
      .rsp_fill_count   (rsp_fill_count),
      .rsp_read_offset  (rsp_read_offset),
      .rsp_mark_offset  (rsp_mark_offset),
      .rsp_end_reached  (rsp_end_reached),
      .rsp_grew_flag    (rsp_grew_flag),
      .rsp_full_flag    (rsp_full_flag),
      .rsp_empty_flag   (rsp_empty_flag),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  pending_views.size());
         $display("growable_char_buffer_test: done, errors");
         $finish;
      end
   end

   // buffer view after one operation, updating the copied state
   task automatic apply_buffer_op(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] sym,
                                  input logic [ADDR_W-1:0] pos, output rsp_type view);
      status_type st;
      logic [CHAR_W-1:0] got_char;
      int new_cap;
      int room;
      st = ST_OK;
      got_char = '0;
      case (op)
         OP_INIT: begin
            if (cfg_mode == MODE_BAD || (cfg_mode == MODE_FIXED && cfg_start == '0) ||
                (cfg_mode == MODE_MUL && cfg_factor > PERCENT_FULL)) begin
               st = ST_BADCFG;
            end else begin
               latched_mode = (cfg_factor == '0) ? MODE_FIXED : cfg_mode;
               latched_factor = (latched_mode == MODE_FIXED) ? '0 : cfg_factor;
               view_cap = cfg_start;
               view_fill = '0;
               view_rd = '0;
               view_mark = '0;
               view_end = 1'b0;
               view_grew = 1'b0;
            end
         end
         OP_APPEND: begin
            view_grew = 1'b0;
            if (view_fill < view_cap) begin
               char_copy[view_fill] = sym;
               view_fill++;
            end else if (latched_mode != MODE_FIXED && view_cap != MAX_CAP) begin
               if (latched_mode == MODE_ADD) begin
                  new_cap = int'(view_cap) + int'(latched_factor);
                  view_cap = (new_cap > int'(MAX_CAP)) ? MAX_CAP : ADDR_W'(new_cap);
               end else begin
                  room = int'(MAX_CAP) - int'(view_cap);
                  new_cap = int'(view_cap) + room * int'(latched_factor) / int'(PERCENT_FULL);
                  // a zero step or an overshoot goes straight to the top
                  view_cap = (new_cap >= int'(MAX_CAP) || new_cap <= int'(view_cap)) ?
                             MAX_CAP : ADDR_W'(new_cap);
               end
               view_grew = 1'b1;
               char_copy[view_fill] = sym;
               view_fill++;
            end else begin
               st = ST_REFUSED;
            end
         end
         OP_GET: begin
            if (view_rd >= view_fill) begin
               view_end = 1'b1;
               st = ST_END;
            end else begin
               view_end = 1'b0;
               got_char = char_copy[view_rd];
               view_rd++;
            end
         end
         OP_MARK: begin
            if (pos > view_fill) st = ST_BADPOS;
            else view_mark = pos;
         end
         OP_RETRACT: begin
            if (view_rd == '0) st = ST_UNDER;
            else view_rd--;
         end
         OP_RESET_TO_MARK: view_rd = view_mark;
         OP_REWIND: begin
            view_rd = '0;
            view_mark = '0;
         end
         OP_CLEAR: begin
            view_fill = '0;
            view_rd = '0;
            view_mark = '0;
            view_end = 1'b0;
            view_grew = 1'b0;
         end
         OP_COMPACT: begin
            if (view_fill >= MAX_CAP) begin
               view_grew = 1'b0;
               st = ST_REFUSED;
            end else begin
               view_cap = view_fill + 1'b1;
               view_grew = 1'b1;
               char_copy[view_fill] = sym;
               view_fill++;
            end
         end
         OP_READ_AT: begin
            if (pos >= view_fill) st = ST_BADPOS;
            else got_char = char_copy[pos];
         end
         default: ;
      endcase
      view.status = st;
      view.data_char = got_char;
      view.cur_capacity = view_cap;
      view.fill_count = view_fill;
      view.read_offset = view_rd;
      view.mark_offset = view_mark;
      view.end_reached = view_end;
      view.grew_flag = view_grew;
      view.full_flag = (view_fill == view_cap);
      view.empty_flag = (view_fill == '0);
   endtask

   // holds the request until accepted, then queues the view it should produce
   task automatic issue_request(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] sym,
                                input logic [ADDR_W-1:0] pos, input bit typed = 1'b0,
                                input status_type want_status = ST_OK,
                                input logic [CHAR_W-1:0] want_char = '0);
      int gap;
      rsp_type view;
      gap = 0;
      if (!calm && $urandom_range(0, 3) == 0)
         gap = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_symbol <= sym;
      req_position <= pos;
      do @(posedge clock); while (!req_ready);
      apply_buffer_op(op, sym, pos, view);
      if (typed) begin
         view.status = want_status;
         view.data_char = want_char;
      end
      pending_views.push_back(view);
      requests_sent++;
   endtask

   task automatic random_request();
      int pick;
      logic [OP_W-1:0] op;
      logic [ADDR_W-1:0] pos;
      pick = $urandom_range(0, 99);
      if (pick < 30) op = OP_APPEND;
      else if (pick < 42) op = OP_GET;
      else if (pick < 54) op = OP_READ_AT;
      else if (pick < 60) op = OP_MARK;
      else if (pick < 66) op = OP_RETRACT;
      else if (pick < 70) op = OP_RESET_TO_MARK;
      else if (pick < 73) op = OP_REWIND;
      else if (pick < 76) op = OP_CLEAR;
      else if (pick < 81) op = OP_COMPACT;
      else if (pick < 84) op = OP_INIT;
      else if (pick < 87) op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      else op = OP_APPEND;
      // mostly positions from zero up to the fill count, sometimes anywhere
      if ($urandom_range(0, 3) != 0) pos = ADDR_W'($urandom_range(0, view_fill));
      else pos = ADDR_W'($urandom());
      issue_request(op, CHAR_W'($urandom()), pos);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_views.size() != 0);
   endtask

   // only called with nothing in flight
   task automatic load_policy(input policy_type p);
      logic [CSR_DATA_W-1:0] val;
      csr_idx_type idx;
      int last;
      last = ($urandom_range(0, 3) == 0) ? 3 : 2;
      for (int i = 0; i <= last; i++) begin
         idx = csr_idx_type'(i);
         case (idx)
            CSR_GROW_MODE:   val = {10'($urandom()), p.mode};
            CSR_GROW_FACTOR: val = {4'($urandom()), p.factor};
            CSR_START_CAP:   val = p.start;
            default:         val = CSR_DATA_W'($urandom());
         endcase
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data <= val;
         do @(posedge clock); while (!csr_ready);
         case (idx)
            CSR_GROW_MODE:   cfg_mode = mode_type'(val[MODE_W-1:0]);
            CSR_GROW_FACTOR: cfg_factor = val[FACTOR_W-1:0];
            CSR_START_CAP:   cfg_start = val[ADDR_W-1:0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
      phases_run++;
   endtask

   task automatic random_phase(input policy_type p, input int n_ops);
      drain_results();
      load_policy(p);
      calm = ($urandom_range(0, 4) == 0);
      issue_request(OP_INIT, CHAR_W'($urandom()), ADDR_W'($urandom()));
      repeat (n_ops) random_request();
   endtask

   task automatic compare_view();
      rsp_type got;
      rsp_type want;
      string diffs;
      got.status = status_type'(rsp_status);
      got.data_char = rsp_data_char;
      got.cur_capacity = rsp_cur_capacity;
      got.fill_count = rsp_fill_count;
      got.read_offset = rsp_read_offset;
      got.mark_offset = rsp_mark_offset;
      got.end_reached = rsp_end_reached;
      got.grew_flag = rsp_grew_flag;
      got.full_flag = rsp_full_flag;
      got.empty_flag = rsp_empty_flag;
      views_checked++;
      if (pending_views.size() == 0) begin
         bad_views++;
         if (bad_views <= 10)
            $display("result %0d arrived with no request outstanding", views_checked);
         return;
      end
      want = pending_views.pop_front();
      diffs = "";
      if (got.status !== want.status)
         diffs = {diffs, $sformatf(" status %0d/%0d", want.status, got.status)};
      if (got.data_char !== want.data_char)
         diffs = {diffs, $sformatf(" char %h/%h", want.data_char, got.data_char)};
      if (got.cur_capacity !== want.cur_capacity)
         diffs = {diffs, $sformatf(" cap %0d/%0d", want.cur_capacity, got.cur_capacity)};
      if (got.fill_count !== want.fill_count)
         diffs = {diffs, $sformatf(" fill %0d/%0d", want.fill_count, got.fill_count)};
      if (got.read_offset !== want.read_offset)
         diffs = {diffs, $sformatf(" rd %0d/%0d", want.read_offset, got.read_offset)};
      if (got.mark_offset !== want.mark_offset)
         diffs = {diffs, $sformatf(" mark %0d/%0d", want.mark_offset, got.mark_offset)};
      if (got.end_reached !== want.end_reached)
         diffs = {diffs, $sformatf(" end %b/%b", want.end_reached, got.end_reached)};
      if (got.grew_flag !== want.grew_flag)
         diffs = {diffs, $sformatf(" grew %b/%b", want.grew_flag, got.grew_flag)};
      if (got.full_flag !== want.full_flag)
         diffs = {diffs, $sformatf(" full %b/%b", want.full_flag, got.full_flag)};
      if (got.empty_flag !== want.empty_flag)
         diffs = {diffs, $sformatf(" empty %b/%b", want.empty_flag, got.empty_flag)};
      if (diffs != "") begin
         bad_views++;
         if (bad_views <= 10)
            $display("result %0d differs (expected/actual):%s", views_checked, diffs);
      end
   endtask

   // result side: check on handshake, then choose next cycle's ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) compare_view();
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            hold_left = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 24) :
                                                        $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      policy_type p;
      int budget;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < $size(directed_rows); i++)
         issue_request(directed_rows[i].op, directed_rows[i].symbol, directed_rows[i].position,
                       directed_rows[i].typed, directed_rows[i].want_status,
                       directed_rows[i].want_char);
      budget = requests_sent + RANDOM_REQUESTS;
      foreach (fixed_policies[i])
         random_phase(fixed_policies[i], $urandom_range(90, 160));
      while (requests_sent < budget) begin
         p.mode = mode_type'($urandom_range(0, 3));
         p.factor = ($urandom_range(0, 3) == 0) ? FACTOR_W'($urandom()) :
                                                  FACTOR_W'($urandom_range(0, 100));
         p.start = ($urandom_range(0, 4) == 0) ? ADDR_W'($urandom()) :
                                                 ADDR_W'($urandom_range(0, 64));
         random_phase(p, $urandom_range(60, 160));
      end
      drain_results();
      repeat (10) @(posedge clock);
      $display("%0d requests under %0d register settings, with growth and refusal cases mixed in",
               requests_sent, phases_run);
      $display("%0d results compared, %0d mismatching", views_checked, bad_views);
      if (bad_views == 0 && pending_views.size() == 0)
         $display("growable_char_buffer_test: done, clean");
      else
         $display("growable_char_buffer_test: done, errors");
      $finish;
   end

endmodule

[files.f]
rtl/gcb_pkg.sv
rtl/gcb_char_ram.sv
rtl/gcb_grow_unit.sv
rtl/growable_char_buffer.sv
bench/growable_char_buffer_test.sv
